// ===== sv/bezier_de_casteljau_split_top_macros.svh =====
// assertion macros shared by the checker of the bezier split block
// depends on nothing; included by bdcs_checker.sv
`ifndef BEZIER_DE_CASTELJAU_SPLIT_TOP_MACROS_SVH
`define BEZIER_DE_CASTELJAU_SPLIT_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define BDCS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, also checked during reset
`define BDCS_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bdcs_pkg.sv =====
// types, constants and lerp helpers of the bezier split block
// depends on nothing; used by the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package bdcs_pkg;

    localparam int T_FRAC_BITS = 16;
    localparam int T_W         = T_FRAC_BITS + 1;
    // (b - a) is 33 bits signed, t is T_W bits unsigned
    localparam int PROD_W      = 33 + T_W + 1;

    localparam logic OP_QUAD  = 1'b0;
    localparam logic OP_CUBIC = 1'b1;

    typedef logic signed [31:0]       coord_t;
    typedef logic [T_W-1:0]           t_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam t_t    T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam prod_t RND   = prod_t'(1) <<< (T_FRAC_BITS - 1);

    typedef struct packed {
        logic   opcode;
        t_t     split_t;
        coord_t p0_x;
        coord_t p0_y;
        coord_t p1_x;
        coord_t p1_y;
        coord_t p2_x;
        coord_t p2_y;
        coord_t p3_x;
        coord_t p3_y;
    } in_t;

    typedef struct packed {
        logic       half;
        logic [1:0] point_index;
        coord_t     out_x;
        coord_t     out_y;
        logic       last;
    } out_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } pt_t;

    typedef struct packed {
        prod_t x;
        prod_t y;
    } ppt_t;

    // everything one curve carries down the pipeline
    typedef struct packed {
        logic           cubic;
        t_t             t;
        pt_t  [3:0]     p;
        pt_t  [2:0]     lv1;
        pt_t  [1:0]     lv2;
        pt_t            mid;
        ppt_t [2:0]     prod;
    } work_t;

    // (b - a) * t
    function automatic prod_t mul_diff(coord_t a, coord_t b, t_t t);
        logic signed [32:0] diff;
        logic signed [T_W:0] tt;
        diff = {b[31], b} - {a[31], a};
        tt   = {1'b0, t};
        return prod_t'(diff) * prod_t'(tt);
    endfunction

    // floor((a << T_FRAC_BITS + prod + half) >> T_FRAC_BITS), always fits 32 bits
    function automatic coord_t lerp_fin(coord_t a, prod_t q);
        prod_t sum;
        sum = {{(PROD_W - 32 - T_FRAC_BITS){a[31]}}, a, {T_FRAC_BITS{1'b0}}} + q + RND;
        return sum[T_FRAC_BITS+31:T_FRAC_BITS];
    endfunction

    function automatic ppt_t mul_pt(pt_t a, pt_t b, t_t t);
        ppt_t r;
        r.x = mul_diff(a.x, b.x, t);
        r.y = mul_diff(a.y, b.y, t);
        return r;
    endfunction

    function automatic pt_t fin_pt(pt_t a, ppt_t q);
        pt_t r;
        r.x = lerp_fin(a.x, q.x);
        r.y = lerp_fin(a.y, q.y);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bezier_de_casteljau_split_top.sv =====
// de casteljau split of a quadratic or cubic bezier curve, one control point per result
// depends on bdcs_pkg
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | transaction                     | handshake
//  s_      | in        | one curve + split t (in_t)      | s_valid / s_ready
//  m_      | out       | one control point (out_t)       | m_valid / m_ready
//
//  a curve passes seven register stages (three multiply + three add levels after
//  the input register), then an unloader that puts one point per cycle on m_ while
//  the output register is free; a cubic gives 8 results and a quadratic 6, and the
//  single-point output port limits the curve rate; the unloader takes the next curve
//  as the last point of the current one leaves, while earlier stages hold later curves
//  reset clears all valid bits and the point counter; payload is not reset
//  m_ready low holds the output register; the stages fill up and s_ready drops
//  only when every stage holds a curve and the unloader cannot take one

module bezier_de_casteljau_split_top
    import bdcs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int NST = 7;

    // pipeline stages
    work_t            st_reg  [1:NST];
    work_t            st_next [1:NST];
    logic [NST:1]     vld_reg;
    logic [NST:1]     vin;
    logic [NST+1:1]   rdy;

    // unloader and output register
    work_t            ser_reg;
    logic             ser_vld_reg;
    logic [2:0]       cnt_reg;
    out_t             m_data_reg;
    logic             m_valid_reg;

    logic             out_free;
    logic             fire;
    logic             ser_last;
    logic             ser_take;
    out_t             sel;
    pt_t              sel_pt;

    // ready ripples back from the unloader; a stage moves when empty or when drained
    always_comb begin
        rdy[NST+1] = ser_take;
        for (int k = NST; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vin[1] = s_valid;
        for (int k = 2; k <= NST; k++) begin
            vin[k] = vld_reg[k-1];
        end
    end

    assign s_ready = rdy[1];

    always_comb begin
        // stage 1: capture, saturate t to one
        st_next[1]       = '0;
        st_next[1].cubic = (s_data.opcode == OP_CUBIC);
        st_next[1].t     = (s_data.split_t > T_ONE) ? T_ONE : s_data.split_t;
        st_next[1].p[0]  = '{x: s_data.p0_x, y: s_data.p0_y};
        st_next[1].p[1]  = '{x: s_data.p1_x, y: s_data.p1_y};
        st_next[1].p[2]  = '{x: s_data.p2_x, y: s_data.p2_y};
        st_next[1].p[3]  = '{x: s_data.p3_x, y: s_data.p3_y};

        // stages 2..7: alternate multiply and round for the three lerp levels
        for (int k = 2; k <= NST; k++) begin
            st_next[k] = st_reg[k-1];
        end
        for (int i = 0; i < 3; i++) begin
            st_next[2].prod[i] = mul_pt(st_reg[1].p[i], st_reg[1].p[i+1], st_reg[1].t);
            st_next[3].lv1[i]  = fin_pt(st_reg[2].p[i], st_reg[2].prod[i]);
        end
        for (int i = 0; i < 2; i++) begin
            st_next[4].prod[i] = mul_pt(st_reg[3].lv1[i], st_reg[3].lv1[i+1], st_reg[3].t);
            st_next[5].lv2[i]  = fin_pt(st_reg[4].lv1[i], st_reg[4].prod[i]);
        end
        st_next[6].prod[0] = mul_pt(st_reg[5].lv2[0], st_reg[5].lv2[1], st_reg[5].t);
        st_next[7].mid     = fin_pt(st_reg[6].lv2[0], st_reg[6].prod[0]);
    end

    // unloader: cubic left p0 a d m, right m e c p3; quadratic left p0 a d, right d b p2
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = ser_vld_reg && out_free;
    assign ser_last = ser_reg.cubic ? (cnt_reg == 3'd7) : (cnt_reg == 3'd5);
    assign ser_take = !ser_vld_reg || (fire && ser_last);

    always_comb begin
        sel_pt          = ser_reg.p[0];
        sel.half        = 1'b0;
        sel.point_index = 2'd0;
        case ({ser_reg.cubic, cnt_reg})
            4'b1_000: begin sel_pt = ser_reg.p[0];   sel.half = 1'b0; sel.point_index = 2'd0; end
            4'b1_001: begin sel_pt = ser_reg.lv1[0]; sel.half = 1'b0; sel.point_index = 2'd1; end
            4'b1_010: begin sel_pt = ser_reg.lv2[0]; sel.half = 1'b0; sel.point_index = 2'd2; end
            4'b1_011: begin sel_pt = ser_reg.mid;    sel.half = 1'b0; sel.point_index = 2'd3; end
            4'b1_100: begin sel_pt = ser_reg.mid;    sel.half = 1'b1; sel.point_index = 2'd0; end
            4'b1_101: begin sel_pt = ser_reg.lv2[1]; sel.half = 1'b1; sel.point_index = 2'd1; end
            4'b1_110: begin sel_pt = ser_reg.lv1[2]; sel.half = 1'b1; sel.point_index = 2'd2; end
            4'b1_111: begin sel_pt = ser_reg.p[3];   sel.half = 1'b1; sel.point_index = 2'd3; end
            4'b0_000: begin sel_pt = ser_reg.p[0];   sel.half = 1'b0; sel.point_index = 2'd0; end
            4'b0_001: begin sel_pt = ser_reg.lv1[0]; sel.half = 1'b0; sel.point_index = 2'd1; end
            4'b0_010: begin sel_pt = ser_reg.lv2[0]; sel.half = 1'b0; sel.point_index = 2'd2; end
            4'b0_011: begin sel_pt = ser_reg.lv2[0]; sel.half = 1'b1; sel.point_index = 2'd0; end
            4'b0_100: begin sel_pt = ser_reg.lv1[1]; sel.half = 1'b1; sel.point_index = 2'd1; end
            4'b0_101: begin sel_pt = ser_reg.p[2];   sel.half = 1'b1; sel.point_index = 2'd2; end
            default: begin
                sel_pt          = ser_reg.p[0];
                sel.half        = 1'b0;
                sel.point_index = 2'd0;
            end
        endcase
        sel.out_x = sel_pt.x;
        sel.out_y = sel_pt.y;
        sel.last  = ser_last;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            ser_vld_reg <= 1'b0;
            cnt_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int k = 1; k <= NST; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vin[k];
                end
            end
            if (ser_take) begin
                ser_vld_reg <= vld_reg[NST];
            end
            if (fire) begin
                cnt_reg     <= ser_last ? 3'd0 : cnt_reg + 3'd1;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        for (int k = 1; k <= NST; k++) begin
            if (rdy[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
        if (ser_take) begin
            ser_reg <= st_reg[NST];
        end
        if (fire) begin
            m_data_reg <= sel;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== sv/bdcs_checker.sv =====
// port-level checks of the bezier split block, bound to the top level
// depends on bdcs_pkg and bezier_de_casteljau_split_top_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "bezier_de_casteljau_split_top_macros.svh"

module bdcs_checker
    import bdcs_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire in_t  s_data,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    // a stalled result holds
    `BDCS_ASSERT_NEXT(a_m_hold, aclk, aresetn && m_valid && !m_ready,
                      m_valid && $stable(m_data), "result changed while stalled")

    // a stalled input holds
    `BDCS_ASSERT_NEXT(a_s_hold, aclk, aresetn && s_valid && !s_ready,
                      s_valid && $stable(s_data), "input changed while stalled")

    // the final point closes the right curve
    `BDCS_ASSERT_NOW(a_last_shape, aclk, aresetn, m_valid && m_data.last,
                     m_data.half && m_data.point_index[1], "last flag on a wrong point")

    // nothing shows right after reset
    `BDCS_ASSERT_NEXT(a_rst_idle, aclk, !aresetn, !m_valid, "result valid after reset")

endmodule

bind bezier_de_casteljau_split_top bdcs_checker u_bdcs_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking bench for the bezier de casteljau split block: directed and random curves
// depends on bdcs_pkg and bezier_de_casteljau_split_top; expected points are computed here
`timescale 1ns / 1ps

module testbench;
    import bdcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transaction on either channel
    localparam int DRAIN_CYCLES   = 20;     // quiet cycles after the last expected point
    localparam int RANDOM_CURVES  = 202;
    localparam int CALM_START     = 400;    // window of cycles with no gaps and no stalls
    localparam int CALM_STOP      = 900;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    in_t  curve_queue[$];       // curves waiting to be driven
    out_t expected_points[$];   // control points predicted for accepted curves

    bit curve_taken    = 1'b0;  // set at the rising edge that accepts the driven curve
    int cycle_count    = 0;
    int idle_cycles    = 0;
    int mismatch_count = 0;
    int quad_count     = 0;
    int cubic_count    = 0;
    int clamped_count  = 0;
    int point_count    = 0;

    bezier_de_casteljau_split_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // a*(1-t) + b*t with round half up; exact in 64 bits, result always fits 32
    function automatic coord_t blend_coord(coord_t a, coord_t b, t_t t);
        longint acc;
        acc = (longint'(a) <<< T_FRAC_BITS) + (longint'(b) - longint'(a)) * longint'(t)
              + (longint'(1) <<< (T_FRAC_BITS - 1));
        return coord_t'(acc >>> T_FRAC_BITS);
    endfunction

    // split one curve and queue its left then right control points
    task automatic predict_split(input in_t c);
        t_t     t;
        coord_t px[4], py[4], lx[4], ly[4], rx[4], ry[4];
        coord_t ax, ay, bx, by, cx, cy, dx, dy, ex, ey, mx, my;
        int     n;
        out_t   pt;
        t  = (c.split_t > T_ONE) ? T_ONE : c.split_t;
        px = '{c.p0_x, c.p1_x, c.p2_x, c.p3_x};
        py = '{c.p0_y, c.p1_y, c.p2_y, c.p3_y};
        ax = blend_coord(px[0], px[1], t);
        ay = blend_coord(py[0], py[1], t);
        bx = blend_coord(px[1], px[2], t);
        by = blend_coord(py[1], py[2], t);
        if (c.opcode == OP_CUBIC) begin
            n  = 4;
            cx = blend_coord(px[2], px[3], t);
            cy = blend_coord(py[2], py[3], t);
            dx = blend_coord(ax, bx, t);
            dy = blend_coord(ay, by, t);
            ex = blend_coord(bx, cx, t);
            ey = blend_coord(by, cy, t);
            mx = blend_coord(dx, ex, t);
            my = blend_coord(dy, ey, t);
            lx = '{px[0], ax, dx, mx};
            ly = '{py[0], ay, dy, my};
            rx = '{mx, ex, cx, px[3]};
            ry = '{my, ey, cy, py[3]};
            cubic_count++;
        end else begin
            n  = 3;
            mx = blend_coord(ax, bx, t);
            my = blend_coord(ay, by, t);
            lx = '{px[0], ax, mx, 0};
            ly = '{py[0], ay, my, 0};
            rx = '{mx, bx, px[2], 0};
            ry = '{my, by, py[2], 0};
            quad_count++;
        end
        if (c.split_t > T_ONE)
            clamped_count++;
        for (int h = 0; h < 2; h++) begin
            for (int i = 0; i < n; i++) begin
                pt.half        = logic'(h);
                pt.point_index = 2'(i);
                pt.out_x       = (h == 0) ? lx[i] : rx[i];
                pt.out_y       = (h == 0) ? ly[i] : ry[i];
                pt.last        = (h == 1) && (i == n - 1);
                expected_points = {expected_points, pt};
            end
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic queue_curve(input logic op, input t_t t,
                               input coord_t x0, input coord_t y0,
                               input coord_t x1, input coord_t y1,
                               input coord_t x2, input coord_t y2,
                               input coord_t x3, input coord_t y3);
        in_t c;
        c = '{opcode: op, split_t: t, p0_x: x0, p0_y: y0, p1_x: x1, p1_y: y1,
              p2_x: x2, p2_y: y2, p3_x: x3, p3_y: y3};
        curve_queue = {curve_queue, c};
    endtask

    // mostly full-range values, with extremes and small values mixed in
    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return coord_t'($urandom_range(0, 2 * 1048576)) - 32'sd1048576;
            default: return coord_t'($urandom);
        endcase
    endfunction

    // t mostly inside [0, 1], plus the edges and values above one
    function automatic t_t pick_split_t();
        case ($urandom_range(0, 9))
            0:       return t_t'(0);
            1:       return T_ONE;
            2:       return t_t'($urandom_range(T_ONE + 1, (1 << T_W) - 1));
            3:       return t_t'($urandom);
            default: return t_t'($urandom_range(0, T_ONE));
        endcase
    endfunction

    // a gap with a chance of about 11 in a hundred, none inside the calm window
    function automatic bit gap_now();
        if (cycle_count >= CALM_START && cycle_count < CALM_STOP)
            return 1'b0;
        return $urandom_range(0, 99) < 11;
    endfunction

    // ---------------------------------------------------------------
    // driver: inputs change on the falling edge only
    // ---------------------------------------------------------------

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            // result side stalls at random
            m_ready <= !gap_now();
            // load a new curve once the previous one is taken, or after a gap
            if (!s_valid || curve_taken) begin
                curve_taken = 1'b0;
                if (curve_queue.size() != 0 && !gap_now()) begin
                    s_data  <= curve_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: sample both channels on the rising edge
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            cycle_count++;
            // input transaction: predict its points right away
            if (s_valid && s_ready) begin
                predict_split(s_data);
                curve_taken = 1'b1;
            end
            // output transaction: compare with the oldest prediction
            if (m_valid && m_ready) begin
                point_count++;
                if (expected_points.size() == 0) begin
                    $error("unexpected point: half %0d index %0d x %0d y %0d",
                           m_data.half, m_data.point_index, m_data.out_x, m_data.out_y);
                    mismatch_count++;
                end else begin
                    want = expected_points.pop_front();
                    if (m_data.half !== want.half) begin
                        $error("half: expected %0d, got %0d", want.half, m_data.half);
                        mismatch_count++;
                    end
                    if (m_data.point_index !== want.point_index) begin
                        $error("point_index: expected %0d, got %0d",
                               want.point_index, m_data.point_index);
                        mismatch_count++;
                    end
                    if (m_data.out_x !== want.out_x) begin
                        $error("out_x: expected %0d, got %0d", want.out_x, m_data.out_x);
                        mismatch_count++;
                    end
                    if (m_data.out_y !== want.out_y) begin
                        $error("out_y: expected %0d, got %0d", want.out_y, m_data.out_y);
                        mismatch_count++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_data.last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: too long with no transaction on either side
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d cycles with no transaction", idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // sequence: directed curves, random curves, reset, drain, verdict
    // ---------------------------------------------------------------

    initial begin
        coord_t hi, lo;
        hi = 32'sh7FFF_FFFF;
        lo = 32'sh8000_0000;

        // all-zero curve and t at zero
        queue_curve(OP_QUAD, t_t'(0), 0, 0, 0, 0, 0, 0, 0, 0);
        // largest swings between neighbors, t at one
        queue_curve(OP_CUBIC, T_ONE, hi, lo, lo, hi, hi, lo, lo, hi);
        // t above one is clamped
        queue_curve(OP_QUAD, t_t'((1 << T_W) - 1), lo, hi, hi, lo, lo, hi, 0, 0);
        queue_curve(OP_CUBIC, T_ONE + t_t'(1), hi, lo, lo, hi, hi, lo, lo, hi);
        // flat curves at both extremes
        queue_curve(OP_CUBIC, t_t'(32768), hi, hi, hi, hi, hi, hi, hi, hi);
        queue_curve(OP_CUBIC, t_t'(32768), lo, lo, lo, lo, lo, lo, lo, lo);
        // exact halfway rounding, both signs; quadratic ignores the fourth point
        queue_curve(OP_QUAD, t_t'(32768), 0, 0, 1, -1, 0, 0, 32'sh1234_5678, -32'sd77);
        queue_curve(OP_CUBIC, t_t'(32768), 0, 0, 1, -1, 0, 0, 1, -1);
        queue_curve(OP_CUBIC, t_t'(32768), -3, 3, 0, 0, -1, 1, 2, -2);
        // t just above zero and just below one
        queue_curve(OP_CUBIC, t_t'(1), lo, hi, hi, lo, lo, hi, hi, lo);
        queue_curve(OP_CUBIC, T_ONE - t_t'(1), lo, hi, hi, lo, lo, hi, hi, lo);
        queue_curve(OP_QUAD, t_t'(1), hi, lo, lo, hi, hi, lo, 0, 0);
        queue_curve(OP_QUAD, T_ONE - t_t'(1), hi, lo, lo, hi, hi, lo, 0, 0);
        // t at the ends with extreme points
        queue_curve(OP_QUAD, t_t'(0), hi, lo, lo, hi, hi, lo, hi, hi);
        queue_curve(OP_QUAD, T_ONE, lo, hi, hi, lo, lo, hi, lo, lo);
        queue_curve(OP_CUBIC, t_t'(0), lo, hi, hi, lo, lo, hi, hi, lo);
        // ordinary q16.16 values
        queue_curve(OP_CUBIC, t_t'(21845), 32'sh0001_0000, -32'sh0002_8000, 32'sh0010_0000,
                    32'sh0000_4000, -32'sh0003_0000, 32'sh0007_0000, 32'sh0000_0001, 0);
        queue_curve(OP_QUAD, t_t'(49152), -32'sh0001_0000, 32'sh0005_0000, 32'sh0002_0000,
                    -32'sh0004_0000, 32'sh0009_0000, 32'sh0000_8000, 0, 0);

        // random curves with full-range content
        for (int i = 0; i < RANDOM_CURVES; i++)
            queue_curve(logic'($urandom_range(0, 1)), pick_split_t(),
                        pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord(), pick_coord(), pick_coord());

        // synchronous reset held low from the start, released on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all curves handed over
        while (curve_queue.size() != 0 || s_valid)
            @(posedge aclk);
        // all predicted points seen
        while (expected_points.size() != 0)
            @(posedge aclk);
        // stay a little longer to catch stray points
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d quadratic and %0d cubic splits, %0d with t clamped to one",
                 quad_count, cubic_count, clamped_count);
        $display("compared %0d control points, %0d field mismatches",
                 point_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bdcs_pkg.sv
sv/bezier_de_casteljau_split_top.sv
sv/bdcs_checker.sv
verif/testbench.sv
